// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/acr_pkg.sv =====
`timescale 1ns / 1ps

package acr_pkg;

    localparam int unsigned DEFAULT_CACHE_ENTRIES = 16;

    localparam logic [31:0] TAG_RESET     = 32'd1211;
    localparam logic [47:0] BROADCAST_MAC = 48'hffff_ffff_ffff;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_IP  = 2'd0;
    localparam logic [1:0] CFG_OWN_MAC = 2'd1;
    localparam logic [1:0] CFG_MSG_TAG = 2'd2;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_GONE  = 2'd2
    } cmd_t;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_REPLY   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic        complete;
        logic        pending;
        logic [7:0]  client;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_en;
        logic commit;
    } acr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic act_ready;
    } acr_stat_t;

endpackage

// ===== sv/acr_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acr_ctrl import acr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  acr_stat_t stat,
    output acr_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ACT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_ACT;
            end
            ST_ACT: begin
                if (stat.act_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "accepted while busy")
    `ASSERT_CLK(a_drain_after_last, aclk, aresetn, (state_reg == ST_DRAIN) |-> $past(stat.scan_last), "drain without last scan")
    `ASSERT_CLK(a_commit_once, aclk, aresetn, cmd.commit |=> !cmd.commit, "double commit")

endmodule

// ===== sv/acr_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acr_datapath import acr_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_msg_tag,
    input  logic        s_frame_op,
    input  logic [47:0] s_sender_mac,
    input  logic [31:0] s_sender_ip,
    input  logic [31:0] s_target_ip,
    input  logic [31:0] s_query_ip,
    input  logic [7:0]  s_client_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [47:0] m_dst_mac,
    output logic [31:0] m_out_target_ip,
    output logic [7:0]  m_reply_client,
    output logic [47:0] m_resolved_mac,
    input  acr_cmd_t    cmd,
    output acr_stat_t   stat
);

    localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);

    // configuration
    logic [31:0] own_ip_reg;
    logic [31:0] tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg <= '0;
            tag_reg    <= TAG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OWN_IP:  own_ip_reg <= cfg_data[31:0];
                CFG_OWN_MAC: ; // sender address of outgoing frames, not part of any result
                CFG_MSG_TAG: tag_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // latched transaction
    cmd_t        in_cmd_reg;
    logic [31:0] in_tag_reg;
    op_t         in_op_reg;
    logic [47:0] in_smac_reg;
    logic [31:0] in_sip_reg;
    logic [31:0] in_tip_reg;
    logic [31:0] in_qip_reg;
    logic [7:0]  in_client_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_cmd_reg    <= cmd_t'(s_command);
            in_tag_reg    <= s_msg_tag;
            in_op_reg     <= op_t'(s_frame_op);
            in_smac_reg   <= s_sender_mac;
            in_sip_reg    <= s_sender_ip;
            in_tip_reg    <= s_target_ip;
            in_qip_reg    <= s_query_ip;
            in_client_reg <= s_client_tag;
        end
    end

    // entry memory and valid bits
    entry_t                    mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0]  valid_reg;
    logic [IDX_W-1:0]          scan_idx_reg;
    entry_t                    rd_word_reg;
    logic                      rd_ev_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_en;
            if (cmd.capture) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_en) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_word_reg <= mem[scan_idx_reg];
        rd_ev_reg   <= valid_reg[scan_idx_reg];
        rd_idx_reg  <= scan_idx_reg;
    end

    assign stat.scan_last = (scan_idx_reg == IDX_W'(CACHE_ENTRIES - 1));

    // match on the entry read the cycle before
    logic [31:0] key_ip;
    logic        eval_match;

    always_comb begin
        key_ip = (in_cmd_reg == CMD_QUERY) ? in_qip_reg : in_sip_reg;
        if (in_cmd_reg == CMD_GONE) begin
            eval_match = rd_ev_reg && !rd_word_reg.complete && rd_word_reg.pending &&
                         (rd_word_reg.client == in_client_reg);
        end else begin
            eval_match = rd_ev_reg && (rd_word_reg.ip == key_ip);
        end
    end

    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    entry_t           hit_word_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.capture) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            // lowest index wins
            if (eval_match && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            if (!rd_ev_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg && eval_match && !hit_found_reg) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_word_reg <= rd_word_reg;
        end
        if (rd_vld_reg && !rd_ev_reg && !free_found_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // action
    logic             res_v;
    kind_t            res_kind;
    logic [47:0]      res_dmac;
    logic [31:0]      res_tip;
    logic [7:0]       res_client;
    logic [47:0]      res_rmac;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_word;
    logic             set_v;
    logic             clr_v;

    always_comb begin
        res_v      = 1'b0;
        res_kind   = KIND_REQUEST;
        res_dmac   = '0;
        res_tip    = in_sip_reg;
        res_client = '0;
        res_rmac   = '0;
        wr_en      = 1'b0;
        wr_idx     = hit_idx_reg;
        wr_word    = hit_word_reg;
        set_v      = 1'b0;
        clr_v      = 1'b0;
        unique case (in_cmd_reg)
            CMD_FRAME: begin
                if (in_tag_reg == tag_reg) begin
                    if (in_op_reg == OP_REQUEST) begin
                        if (in_tip_reg == own_ip_reg) begin
                            res_v    = 1'b1;
                            res_kind = KIND_REPLY;
                            res_dmac = in_smac_reg;
                            if (hit_found_reg) begin
                                wr_en            = 1'b1;
                                wr_word.mac      = in_smac_reg;
                                wr_word.complete = 1'b1;
                            end else if (free_found_reg) begin
                                wr_en   = 1'b1;
                                set_v   = 1'b1;
                                wr_idx  = free_idx_reg;
                                wr_word = '{ip: in_sip_reg, mac: in_smac_reg, complete: 1'b1,
                                            pending: 1'b0, client: '0};
                            end
                        end
                    end else if (hit_found_reg) begin
                        wr_en            = 1'b1;
                        wr_word.mac      = in_smac_reg;
                        wr_word.complete = 1'b1;
                        wr_word.pending  = 1'b0;
                        if (hit_word_reg.pending) begin
                            res_v      = 1'b1;
                            res_kind   = KIND_DELIVER;
                            res_client = hit_word_reg.client;
                            res_rmac   = in_smac_reg;
                        end
                    end
                end
            end
            CMD_QUERY: begin
                res_tip = in_qip_reg;
                if (hit_found_reg) begin
                    if (hit_word_reg.complete) begin
                        res_v      = 1'b1;
                        res_kind   = KIND_DELIVER;
                        res_client = in_client_reg;
                        res_rmac   = hit_word_reg.mac;
                    end
                end else if (free_found_reg) begin
                    res_v    = 1'b1;
                    res_kind = KIND_REQUEST;
                    res_dmac = BROADCAST_MAC;
                    wr_en    = 1'b1;
                    set_v    = 1'b1;
                    wr_idx   = free_idx_reg;
                    wr_word  = '{ip: in_qip_reg, mac: '0, complete: 1'b0,
                                 pending: 1'b1, client: in_client_reg};
                end else begin
                    res_v      = 1'b1;
                    res_kind   = KIND_FULL;
                    res_client = in_client_reg;
                end
            end
            CMD_GONE: begin
                clr_v = hit_found_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            mem[wr_idx] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit) begin
            if (set_v) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_v) begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // output register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [47:0] out_dmac_reg;
    logic [31:0] out_tip_reg;
    logic [7:0]  out_client_reg;
    logic [47:0] out_rmac_reg;

    assign stat.act_ready = !res_v || !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit && res_v) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && res_v) begin
            out_kind_reg   <= res_kind;
            out_dmac_reg   <= res_dmac;
            out_tip_reg    <= res_tip;
            out_client_reg <= res_client;
            out_rmac_reg   <= res_rmac;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_dst_mac       = out_dmac_reg;
    assign m_out_target_ip = out_tip_reg;
    assign m_reply_client  = out_client_reg;
    assign m_resolved_mac  = out_rmac_reg;

    `ASSERT_CLK(a_scan_done, aclk, aresetn, cmd.commit |-> !rd_vld_reg, "commit before scan drained")
    `ASSERT_CLK(a_hit_valid, aclk, aresetn, (cmd.commit && hit_found_reg) |-> valid_reg[hit_idx_reg], "hit entry not valid")
    `ASSERT_CLK(a_free_invalid, aclk, aresetn, (cmd.commit && free_found_reg) |-> !valid_reg[free_idx_reg], "free entry already valid")

endmodule

// ===== sv/arp_cache_responder.sv =====
// sequence: a transaction is accepted, the cache is scanned one entry per cycle through
//   the single read port of the entry memory, then a drain and an action state follow
// acceptance: the next transaction is taken only after the previous one commits; the
//   action state waits while the output register holds a result not yet taken
// reset: synchronous active-low aresetn clears all valid bits, the state machine, the
//   output valid and the configuration (own_ip 0, message_tag 1211); no clearing pass
`timescale 1ns / 1ps

module arp_cache_responder import acr_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel, always ready
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // event input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_msg_tag,
    input  logic        s_frame_op,
    input  logic [47:0] s_sender_mac,
    input  logic [31:0] s_sender_ip,
    input  logic [31:0] s_target_ip,
    input  logic [31:0] s_query_ip,
    input  logic [7:0]  s_client_tag,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [47:0] m_dst_mac,
    output logic [31:0] m_out_target_ip,
    output logic [7:0]  m_reply_client,
    output logic [47:0] m_resolved_mac
);

    acr_cmd_t  cmd;
    acr_stat_t stat;

    // configuration registers live in the datapath and take every transaction at once
    assign cfg_ready = 1'b1;

    // sequencer: idle, scan of the entry memory, drain, action
    acr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // entry memory, valid bits, match search, action logic and output register;
    // the output register lets the next transaction in while a result waits
    acr_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_command       (s_command),
        .s_msg_tag       (s_msg_tag),
        .s_frame_op      (s_frame_op),
        .s_sender_mac    (s_sender_mac),
        .s_sender_ip     (s_sender_ip),
        .s_target_ip     (s_target_ip),
        .s_query_ip      (s_query_ip),
        .s_client_tag    (s_client_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_dst_mac       (m_dst_mac),
        .m_out_target_ip (m_out_target_ip),
        .m_reply_client  (m_reply_client),
        .m_resolved_mac  (m_resolved_mac),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
